@@ hw/rtl/assert_macros.svh @@
// assertion macros used by block_zero_run_length_encoder_core.sv
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked on every rising clock edge outside reset
`define BZ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define BZ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BZ_ASSERT(lbl, clk, rst, prop, msg)
`define BZ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hw/rtl/bzrle_pkg.sv @@
// types and constants of the block zero run length encoder
// no dependencies; used by the channel interfaces and the core
package bzrle_pkg;

   localparam int BLOCK_LEN = 64;
   localparam int POS_W     = $clog2(BLOCK_LEN);
   localparam int COEF_W    = 12;
   localparam int WORD_W    = 12;
   localparam int KIND_W    = 2;

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);
   localparam logic signed [WORD_W-1:0] END_MARKER = WORD_W'(63);

   // results one request can produce: run count, value, end marker
   localparam int MAX_RESULTS = 3;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_VALUE = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      kind_type                 kind;
      logic                     last;
   } result_type;

endpackage

@@ hw/rtl/bzrle_if.sv @@
// valid/ready channel interfaces for requests and results
// depends on bzrle_pkg
interface bzrle_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [bzrle_pkg::COEF_W-1:0]    coefficient;

   modport source (output valid, output coefficient, input ready);
   modport sink   (input valid, input coefficient, output ready);
endinterface

interface bzrle_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [bzrle_pkg::WORD_W-1:0]    word;
   bzrle_pkg::kind_type                    kind;
   logic                                   last;

   modport source (output valid, output word, output kind, output last, input ready);
   modport sink   (input valid, input word, input kind, input last, output ready);
endinterface

@@ hw/rtl/block_zero_run_length_encoder_core.sv @@
// Zero run length encoder for 64-coefficient blocks in zigzag order. Each request
// carries one coefficient; it is encoded in the cycle it is accepted and its first
// result word appears on the result port in the next cycle if the output register is
// free. A request yields zero to three words (DC value; run count and value; end
// marker after the last coefficient). The single result port moves one word per
// cycle while the result side is ready: with the result side always ready,
// requests that yield at most one word are accepted every cycle, others hold req
// ready low until their extra words have left a three-entry queue. Result back
// pressure stalls the port and so keeps req ready low longer.
// req ready depends only on that queue being empty.
// depends on bzrle_pkg, bzrle_if.sv and assert_macros.svh
`include "assert_macros.svh"

module block_zero_run_length_encoder_core (
   input logic          clock,
   input logic          reset,
   bzrle_req_if.sink    req_chan,
   bzrle_rsp_if.source  rsp_chan
);

   logic [bzrle_pkg::POS_W-1:0]  position_ff, position_in;
   logic [bzrle_pkg::POS_W-1:0]  zero_run_ff, zero_run_in;

   bzrle_pkg::result_type        rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   bzrle_pkg::result_type        pend_ff [bzrle_pkg::MAX_RESULTS];
   bzrle_pkg::result_type        pend_in [bzrle_pkg::MAX_RESULTS];
   logic [bzrle_pkg::CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;

   bzrle_pkg::result_type        res [bzrle_pkg::MAX_RESULTS];
   logic [bzrle_pkg::CNT_W-1:0]  res_cnt;

   logic                         accept;
   logic                         out_free;
   logic                         at_dc;
   logic                         at_end;
   logic                         coef_nz;

   assign req_chan.ready = (pend_cnt_ff == '0);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign at_dc   = (position_ff == '0);
   assign at_end  = (position_ff == bzrle_pkg::POS_LAST);
   assign coef_nz = (req_chan.coefficient != '0);

   // encode the incoming coefficient into an ordered list of result words
   always_comb begin
      bzrle_pkg::result_type run_word;
      bzrle_pkg::result_type val_word;
      bzrle_pkg::result_type end_word;

      run_word.word = $signed({{(bzrle_pkg::WORD_W - bzrle_pkg::POS_W){1'b0}}, zero_run_ff});
      run_word.kind = bzrle_pkg::KIND_RUN;
      run_word.last = 1'b0;
      val_word.word = req_chan.coefficient;
      val_word.kind = bzrle_pkg::KIND_VALUE;
      val_word.last = 1'b0;
      end_word.word = bzrle_pkg::END_MARKER;
      end_word.kind = bzrle_pkg::KIND_END;
      end_word.last = 1'b0;

      for (int i = 0; i < bzrle_pkg::MAX_RESULTS; i++) begin
         res[i] = end_word;
      end
      res_cnt = '0;

      if (at_dc) begin
         res[0]  = val_word;
         res_cnt = bzrle_pkg::CNT_W'(1);
      end else if (coef_nz) begin
         res[0]  = run_word;
         res[1]  = val_word;
         res_cnt = bzrle_pkg::CNT_W'(2);
      end

      // end marker fills the slot after whatever came before it
      if (at_end) begin
         res_cnt = res_cnt + 1'b1;
      end

      for (int i = 0; i < bzrle_pkg::MAX_RESULTS; i++) begin
         res[i].last = (bzrle_pkg::CNT_W'(i + 1) == res_cnt);
      end
   end

   always_comb begin
      position_in = position_ff;
      zero_run_in = zero_run_ff;
      if (accept) begin
         position_in = at_end ? '0 : position_ff + 1'b1;
         zero_run_in = (at_dc || coef_nz || at_end) ? '0 : zero_run_ff + 1'b1;
      end
   end

   // output register and drain queue
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      pend_in      = pend_ff;
      pend_cnt_in  = pend_cnt_ff;

      if (accept) begin
         if (out_free) begin
            rsp_in       = res[0];
            rsp_valid_in = (res_cnt != '0);
            pend_in[0]   = res[1];
            pend_in[1]   = res[2];
            pend_cnt_in  = (res_cnt != '0) ? res_cnt - 1'b1 : '0;
         end else begin
            pend_in     = res;
            pend_cnt_in = res_cnt;
         end
      end else if (out_free) begin
         rsp_in       = pend_ff[0];
         rsp_valid_in = (pend_cnt_ff != '0);
         if (pend_cnt_ff != '0) begin
            pend_in[0]  = pend_ff[1];
            pend_in[1]  = pend_ff[2];
            pend_cnt_in = pend_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         zero_run_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         pend_cnt_ff  <= '0;
      end else begin
         position_ff  <= position_in;
         zero_run_ff  <= zero_run_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_ff.word;
   assign rsp_chan.kind  = rsp_ff.kind;
   assign rsp_chan.last  = rsp_ff.last;

   `BZ_ASSERT(a_run_cleared_at_dc, clock, reset,
      position_ff == '0 |-> zero_run_ff == '0, "zero run not cleared at block start")
   `BZ_ASSERT(a_run_below_position, clock, reset,
      position_ff == '0 || zero_run_ff < position_ff, "zero run longer than coefficients seen")
   `BZ_ASSERT(a_block_wraps, clock, reset,
      accept && at_end |=> position_ff == '0, "position did not wrap after last coefficient")
   `BZ_ASSERT(a_queue_behind_output, clock, reset,
      pend_cnt_ff != '0 |-> rsp_valid_ff, "queued words while output register empty")
   `BZ_ASSERT(a_end_is_last, clock, reset,
      rsp_valid_ff && rsp_ff.kind == bzrle_pkg::KIND_END |-> rsp_ff.last,
      "end marker not flagged last")

endmodule
